@@ hdl/ordered_value_list_table_macros.svh @@
// Assertion macros shared by the checker.
`ifndef ORDERED_VALUE_LIST_TABLE_MACROS_SVH
`define ORDERED_VALUE_LIST_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OVLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ovlt assertion failed");

// Next-cycle implication, disabled during reset.
`define OVLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ovlt assertion failed");

`endif

@@ hdl/ovlt_pkg.sv @@
`default_nettype none

package ovlt_pkg;

    localparam int OVLT_DEPTH       = 64;
    localparam int OVLT_VALUE_WIDTH = 32;

    typedef enum logic [1:0] {
        OP_FRONT   = 2'd0,
        OP_ORDERED = 2'd1,
        OP_DELETE  = 2'd2,
        OP_SEARCH  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STATUS_DONE = 2'd0,
        STATUS_MISS = 2'd1,
        STATUS_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PUT,
        ST_FIN
    } t_state;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_COUNT,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_IDX_M1,
        RD_IDX_P1
    } t_rd_sel;

    typedef struct packed {
        logic    load;
        t_idx_op idx_op;
        logic    pos_from_idx;
        logic    pos_from_count;
        logic    set_found;
        logic    set_miss;
        logic    set_full;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_shift;
        logic    wr_put;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        t_op  in_op;
        t_op  op;
        logic full;
        logic empty;
        logic eq;
        logic ge;
        logic last_scan;
        logic up_end;
        logic dn_end;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ hdl/ovlt_ram.sv @@
`default_nettype none

module ovlt_ram #(
    parameter int WIDTH = ovlt_pkg::OVLT_VALUE_WIDTH,
    parameter int DEPTH = ovlt_pkg::OVLT_DEPTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/ovlt_datapath.sv @@
`default_nettype none

module ovlt_datapath #(
    parameter int DEPTH       = ovlt_pkg::OVLT_DEPTH,
    parameter int VALUE_WIDTH = ovlt_pkg::OVLT_VALUE_WIDTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire ovlt_pkg::t_op          i_in_op,
    input  wire logic [VALUE_WIDTH-1:0] i_in_value,
    input  wire ovlt_pkg::t_cmd         i_cmd,
    output ovlt_pkg::t_sts              o_sts,
    input  wire logic                   i_out_ready,
    output logic                        o_out_valid,
    output ovlt_pkg::t_status           o_out_status,
    output logic                        o_out_found,
    output logic [5:0]                  o_out_position,
    output logic [6:0]                  o_out_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PX = AW + 6;
    localparam int CX = CW + 7;

    ovlt_pkg::t_op     r_op;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [CW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_pos, n_pos;
    logic [CW-1:0]     r_count, n_count;
    ovlt_pkg::t_status r_status, n_status;
    logic              r_found, n_found;
    logic              r_out_valid, n_out_valid;

    logic [CW-1:0]          w_idx_m1, w_idx_p1, w_idx_p2;
    logic [AW-1:0]          w_raddr, w_waddr;
    logic [VALUE_WIDTH-1:0] w_rdata, w_wdata;
    logic [PX-1:0]          w_pos_ext;
    logic [CX-1:0]          w_cnt_ext;

    assign w_idx_m1 = CW'(r_idx - 1'b1);
    assign w_idx_p1 = CW'(r_idx + 1'b1);
    assign w_idx_p2 = CW'(r_idx + 2'd2);

    always_comb begin
        unique case (i_cmd.rd_sel)
            ovlt_pkg::RD_IDX_M1: w_raddr = w_idx_m1[AW-1:0];
            ovlt_pkg::RD_IDX_P1: w_raddr = w_idx_p1[AW-1:0];
            default:             w_raddr = r_idx[AW-1:0];
        endcase
    end

    assign w_waddr = i_cmd.wr_put ? r_pos : r_idx[AW-1:0];
    assign w_wdata = i_cmd.wr_put ? r_val : w_rdata;

    ovlt_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ovlt_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_put | i_cmd.wr_shift),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        unique case (i_cmd.idx_op)
            ovlt_pkg::IDX_ZERO:  n_idx = '0;
            ovlt_pkg::IDX_COUNT: n_idx = r_count;
            ovlt_pkg::IDX_INC:   n_idx = w_idx_p1;
            ovlt_pkg::IDX_DEC:   n_idx = w_idx_m1;
            default:             n_idx = r_idx;
        endcase
    end

    always_comb begin
        priority if (i_cmd.pos_from_idx) begin
            n_pos = r_idx[AW-1:0];
        end else if (i_cmd.pos_from_count) begin
            n_pos = r_count[AW-1:0];
        end else if (i_cmd.load) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos;
        end
    end

    always_comb begin
        priority if (i_cmd.set_full) begin
            n_status = ovlt_pkg::STATUS_FULL;
        end else if (i_cmd.set_miss) begin
            n_status = ovlt_pkg::STATUS_MISS;
        end else if (i_cmd.load) begin
            n_status = ovlt_pkg::STATUS_DONE;
        end else begin
            n_status = r_status;
        end
    end

    assign n_found = i_cmd.set_found | (r_found & ~i_cmd.load);

    always_comb begin
        priority if (i_cmd.cnt_inc) begin
            n_count = CW'(r_count + 1'b1);
        end else if (i_cmd.cnt_dec) begin
            n_count = CW'(r_count - 1'b1);
        end else begin
            n_count = r_count;
        end
    end

    assign n_out_valid = i_cmd.out_load | (r_out_valid & ~i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign w_pos_ext = PX'(r_pos);
    assign w_cnt_ext = CX'(r_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_in_op;
            r_val <= i_in_value;
        end
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_status <= n_status;
        r_found  <= n_found;
        if (i_cmd.out_load) begin
            o_out_status   <= r_status;
            o_out_found    <= r_found;
            o_out_position <= w_pos_ext[5:0];
            o_out_count    <= w_cnt_ext[6:0];
        end
    end

    assign o_out_valid = r_out_valid;

    assign o_sts.in_op     = i_in_op;
    assign o_sts.op        = r_op;
    assign o_sts.full      = (r_count == CW'(DEPTH));
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.eq        = (w_rdata == r_val);
    assign o_sts.ge        = ($signed(w_rdata) >= $signed(r_val));
    assign o_sts.last_scan = (w_idx_p1 == r_count);
    assign o_sts.up_end    = (w_idx_m1 == CW'(r_pos));
    assign o_sts.dn_end    = (w_idx_p2 == r_count);
    assign o_sts.out_free  = ~r_out_valid | i_out_ready;

endmodule

`default_nettype wire

@@ hdl/ovlt_ctrl.sv @@
`default_nettype none

module ovlt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire ovlt_pkg::t_sts i_sts,
    output ovlt_pkg::t_cmd     o_cmd
);

    ovlt_pkg::t_state r_state, n_state;
    logic             w_insert;
    logic             w_in_insert;

    assign w_insert    = (i_sts.op == ovlt_pkg::OP_FRONT) || (i_sts.op == ovlt_pkg::OP_ORDERED);
    assign w_in_insert = (i_sts.in_op == ovlt_pkg::OP_FRONT)
                      || (i_sts.in_op == ovlt_pkg::OP_ORDERED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ovlt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ovlt_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (w_in_insert) begin
                        if (i_sts.full) begin
                            n_state = ovlt_pkg::ST_FIN;
                        end else if (i_sts.empty) begin
                            n_state = ovlt_pkg::ST_PUT;
                        end else if (i_sts.in_op == ovlt_pkg::OP_FRONT) begin
                            n_state = ovlt_pkg::ST_SHIFT_RD;
                        end else begin
                            n_state = ovlt_pkg::ST_SCAN_RD;
                        end
                    end else if (i_sts.empty) begin
                        n_state = ovlt_pkg::ST_FIN;
                    end else begin
                        n_state = ovlt_pkg::ST_SCAN_RD;
                    end
                end
            end
            ovlt_pkg::ST_SCAN_RD: n_state = ovlt_pkg::ST_SCAN_CHK;
            ovlt_pkg::ST_SCAN_CHK: begin
                if (i_sts.op == ovlt_pkg::OP_ORDERED) begin
                    if (i_sts.ge) begin
                        n_state = ovlt_pkg::ST_SHIFT_RD;
                    end else if (i_sts.last_scan) begin
                        n_state = ovlt_pkg::ST_PUT;
                    end else begin
                        n_state = ovlt_pkg::ST_SCAN_RD;
                    end
                end else if (i_sts.eq) begin
                    if (i_sts.op == ovlt_pkg::OP_DELETE && !i_sts.last_scan) begin
                        n_state = ovlt_pkg::ST_SHIFT_RD;
                    end else begin
                        n_state = ovlt_pkg::ST_FIN;
                    end
                end else if (i_sts.last_scan) begin
                    n_state = ovlt_pkg::ST_FIN;
                end else begin
                    n_state = ovlt_pkg::ST_SCAN_RD;
                end
            end
            ovlt_pkg::ST_SHIFT_RD: n_state = ovlt_pkg::ST_SHIFT_WR;
            ovlt_pkg::ST_SHIFT_WR: begin
                if (w_insert) begin
                    n_state = i_sts.up_end ? ovlt_pkg::ST_PUT : ovlt_pkg::ST_SHIFT_RD;
                end else begin
                    n_state = i_sts.dn_end ? ovlt_pkg::ST_FIN : ovlt_pkg::ST_SHIFT_RD;
                end
            end
            ovlt_pkg::ST_PUT: n_state = ovlt_pkg::ST_FIN;
            ovlt_pkg::ST_FIN: begin
                if (i_sts.out_free) begin
                    n_state = ovlt_pkg::ST_IDLE;
                end
            end
            default: n_state = ovlt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.idx_op = ovlt_pkg::IDX_HOLD;
        o_cmd.rd_sel = ovlt_pkg::RD_IDX;
        o_in_ready = 1'b0;
        unique case (r_state)
            ovlt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (w_in_insert) begin
                        if (i_sts.full) begin
                            o_cmd.set_full = 1'b1;
                        end else if (!i_sts.empty) begin
                            o_cmd.idx_op = (i_sts.in_op == ovlt_pkg::OP_FRONT)
                                         ? ovlt_pkg::IDX_COUNT : ovlt_pkg::IDX_ZERO;
                        end
                    end else if (i_sts.empty) begin
                        o_cmd.set_miss = 1'b1;
                    end else begin
                        o_cmd.idx_op = ovlt_pkg::IDX_ZERO;
                    end
                end
            end
            ovlt_pkg::ST_SCAN_RD: begin
                o_cmd.rd_en = 1'b1;
            end
            ovlt_pkg::ST_SCAN_CHK: begin
                if (i_sts.op == ovlt_pkg::OP_ORDERED) begin
                    if (i_sts.ge) begin
                        o_cmd.pos_from_idx = 1'b1;
                        o_cmd.idx_op       = ovlt_pkg::IDX_COUNT;
                    end else if (i_sts.last_scan) begin
                        o_cmd.pos_from_count = 1'b1;
                    end else begin
                        o_cmd.idx_op = ovlt_pkg::IDX_INC;
                    end
                end else if (i_sts.eq) begin
                    o_cmd.pos_from_idx = 1'b1;
                    o_cmd.set_found    = 1'b1;
                    if (i_sts.op == ovlt_pkg::OP_DELETE && i_sts.last_scan) begin
                        o_cmd.cnt_dec = 1'b1;
                    end
                end else if (i_sts.last_scan) begin
                    o_cmd.set_miss = 1'b1;
                end else begin
                    o_cmd.idx_op = ovlt_pkg::IDX_INC;
                end
            end
            ovlt_pkg::ST_SHIFT_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = w_insert ? ovlt_pkg::RD_IDX_M1 : ovlt_pkg::RD_IDX_P1;
            end
            ovlt_pkg::ST_SHIFT_WR: begin
                o_cmd.wr_shift = 1'b1;
                if (w_insert) begin
                    if (!i_sts.up_end) begin
                        o_cmd.idx_op = ovlt_pkg::IDX_DEC;
                    end
                end else if (i_sts.dn_end) begin
                    o_cmd.cnt_dec = 1'b1;
                end else begin
                    o_cmd.idx_op = ovlt_pkg::IDX_INC;
                end
            end
            ovlt_pkg::ST_PUT: begin
                o_cmd.wr_put  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
            end
            ovlt_pkg::ST_FIN: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd.load = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/ordered_value_list_table.sv @@
// Search and delete read the list one entry at a time (read, check) up to the match, and an
// ordered insert up to the first entry not less than its value; insert and delete then move
// each displaced entry (read, write) through the one read port and write port of the RAM.
// Throughput: one operation at a time; the next is taken once the result is in the output
// register. Reset (i_rst_n low, synchronous) empties the list and drops any pending result;
// the entry RAM is not cleared and needs no clearing pass.
`default_nettype none

module ordered_value_list_table #(
    parameter int DEPTH       = ovlt_pkg::OVLT_DEPTH,
    parameter int VALUE_WIDTH = ovlt_pkg::OVLT_VALUE_WIDTH,
    localparam int DW         = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [DW-1:0] s_axis_tdata,  // value
    input  wire logic [1:0]    s_axis_tuser,  // operation
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [15:0]        m_axis_tdata,  // position[5:0], entry_count[12:6], is_empty[13]
    output logic [2:0]         m_axis_tuser   // status[1:0], found[2]
);

    ovlt_pkg::t_cmd    w_cmd;
    ovlt_pkg::t_sts    w_sts;
    ovlt_pkg::t_status w_status;
    logic              w_found;
    logic [5:0]        w_position;
    logic [6:0]        w_count;

    ovlt_ctrl u_ovlt_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ovlt_datapath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ovlt_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_op        (ovlt_pkg::t_op'(s_axis_tuser)),
        .i_in_value     (s_axis_tdata[VALUE_WIDTH-1:0]),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_out_status   (w_status),
        .o_out_found    (w_found),
        .o_out_position (w_position),
        .o_out_count    (w_count)
    );

    assign m_axis_tdata = {2'b00, (w_count == 7'd0), w_count, w_position};
    assign m_axis_tuser = {w_found, w_status};

endmodule

`default_nettype wire

@@ hdl/ovlt_checker.sv @@
`default_nettype none
`include "ordered_value_list_table_macros.svh"

module ovlt_checker #(
    parameter int DEPTH = ovlt_pkg::OVLT_DEPTH
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser
);

    `OVLT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    `OVLT_ASSERT_IMP(a_found_done, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[2], m_axis_tuser[1:0] == ovlt_pkg::STATUS_DONE)

    `OVLT_ASSERT_IMP(a_full_count, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser[1:0] == ovlt_pkg::STATUS_FULL), m_axis_tdata[12:6] == 7'(DEPTH))

    `OVLT_ASSERT_IMP(a_fail_pos, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser[1:0] != ovlt_pkg::STATUS_DONE), m_axis_tdata[5:0] == 6'd0)

endmodule

bind ordered_value_list_table ovlt_checker #(
    .DEPTH (DEPTH)
) u_ovlt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
